[design/header_key_value_extract_top_assert.svh]
// Assertion macros for the header key/value extractor
`ifndef HEADER_KEY_VALUE_EXTRACT_TOP_ASSERT_SVH
`define HEADER_KEY_VALUE_EXTRACT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define HKVE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HKVE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HKVE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define HKVE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[design/hkve_pkg.sv]
// Types and constants for the header key/value extractor
package hkve_pkg;

  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned KEY_W       = 8 * KEY_BYTES;
  localparam int unsigned KEY_LEN_W   = 4;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = KEY_W;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_TEXT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LIMIT = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  typedef enum logic [1:0] {
    CLASS_TRUE  = 2'd0,
    CLASS_FALSE = 2'd1,
    CLASS_OTHER = 2'd2
  } flag_class_t;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_SPACE = 3'd1,
    PH_KEY   = 3'd2,
    PH_SEP   = 3'd3,
    PH_BLANK = 3'd4,
    PH_VALUE = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    NM_START  = 3'd0,
    NM_SIGNED = 3'd1,
    NM_ZERO   = 3'd2,
    NM_XPFX   = 3'd3,
    NM_OCT    = 3'd4,
    NM_DEC    = 3'd5,
    NM_HEX    = 3'd6,
    NM_STOP   = 3'd7
  } num_mode_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // hex digit value, 16 when not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    return d;
  endfunction

  function automatic flag_class_t class_of(input logic [7:0] c);
    flag_class_t k;
    case (c)
      CH_NUL, 8'h54, 8'h74, CH_ONE, 8'h59, 8'h79: k = CLASS_TRUE;
      8'h46, 8'h66, CH_ZERO, 8'h4E, 8'h6E:        k = CLASS_FALSE;
      default:                                    k = CLASS_OTHER;
    endcase
    return k;
  endfunction

endpackage

[design/header_key_value_extract_top.sv]
// Header key/value extractor: streams the value of a configured key and a summary word
`include "header_key_value_extract_top_assert.svh"

// Takes one header byte per cycle and may take a new byte every cycle; the parser
// state updates in the accepting cycle and any result word sits in a single output
// register, so a result appears in the cycle after its byte and input stalls only
// while that register is full and not being taken. A zero byte ends the header,
// yields the summary word (found, number, flag class) and restarts parsing. The user
// writes configuration only while idle; the block itself does not enforce it.
module header_key_value_extract_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [hkve_pkg::CFG_INDEX_W-1:0]   write_index,
  input  logic [hkve_pkg::CFG_DATA_W-1:0]    write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         value_byte,
  output logic                               is_last,
  output logic                               found,
  output logic [31:0]                        number,
  output logic [1:0]                         flag_class
);
  import hkve_pkg::*;

  logic [KEY_W-1:0]     key_text;
  logic [KEY_LEN_W-1:0] key_length;
  logic [7:0]           value_limit;

  phase_t          phase, phase_next;
  logic [POS_W-1:0] match_position, match_position_next;
  logic [31:0]     acc, acc_next;
  num_mode_t       mode, mode_next;
  logic            negate, negate_next;
  logic            saturated, saturated_next;
  logic [7:0]      first_char, first_char_next;
  logic [7:0]      chars_emitted, chars_emitted_next;

  logic            in_fire;
  logic [7:0]      c;
  logic [KEY_LEN_W-1:0] key_len;
  logic [7:0]      key_byte;
  logic [POS_W-1:0] pos_inc;
  logic            value_take;
  logic            emit;
  logic            hit;
  logic [4:0]      d;
  logic [35:0]     acc_wide;
  logic [35:0]     t;
  logic            word_load;
  logic [7:0]      word_byte;
  logic            word_last;
  logic            word_found;
  logic [31:0]     word_number;
  flag_class_t     word_class;

  assign c        = data_byte;
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign key_len  = (key_length > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : key_length;
  assign key_byte = key_text[match_position[2:0]*8 +: 8];
  assign pos_inc  = match_position + POS_W'(1);
  assign d        = digit_of(c);
  assign acc_wide = {4'd0, acc};

  assign value_take = (c != CH_NUL) &&
                      (((phase == PH_BLANK) && !is_blank(c) && !is_eol(c)) ||
                       ((phase == PH_VALUE) && !is_eol(c)));
  assign emit = value_take && (chars_emitted < value_limit);
  assign hit  = (phase == PH_VALUE) || (phase == PH_DONE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text    <= '0;
      key_length  <= KEY_LEN_W'(1);
      value_limit <= 8'd255;
    end else if (write_enable) begin
      case (write_index)
        REG_KEY_TEXT:    key_text    <= write_data[KEY_W-1:0];
        REG_KEY_LENGTH:  key_length  <= write_data[KEY_LEN_W-1:0];
        REG_VALUE_LIMIT: value_limit <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // next parser state
  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    acc_next            = acc;
    mode_next           = mode;
    negate_next         = negate;
    saturated_next      = saturated;
    first_char_next     = first_char;
    chars_emitted_next  = chars_emitted;
    t                   = '0;

    if (c == CH_NUL) begin
      phase_next          = PH_SKIP;
      match_position_next = '0;
      acc_next            = '0;
      mode_next           = NM_START;
      negate_next         = 1'b0;
      saturated_next      = 1'b0;
      first_char_next     = '0;
      chars_emitted_next  = '0;
    end else begin
      case (phase)
        PH_SKIP: if (is_eol(c)) phase_next = PH_SPACE;
        PH_SPACE: begin
          if (!is_blank(c) && !is_eol(c)) begin
            match_position_next = '0;
            if (key_len == '0) begin
              if (c == CH_EQUAL || c == CH_COLON) phase_next = PH_BLANK;
              else phase_next = PH_SKIP;
            end else if (c == key_text[7:0]) begin
              match_position_next = POS_W'(1);
              phase_next = (POS_W'(1) >= POS_W'(key_len)) ? PH_SEP : PH_KEY;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_KEY: begin
          if (c == key_byte) begin
            match_position_next = pos_inc;
            phase_next = (pos_inc >= POS_W'(key_len)) ? PH_SEP : PH_KEY;
          end else begin
            phase_next = is_eol(c) ? PH_SPACE : PH_SKIP;
          end
        end
        PH_SEP: begin
          if (is_blank(c) || is_eol(c)) phase_next = PH_SEP;
          else if (c == CH_EQUAL || c == CH_COLON) phase_next = PH_BLANK;
          else phase_next = PH_SKIP;
        end
        PH_BLANK: begin
          if (is_eol(c)) phase_next = PH_DONE;
          else if (!is_blank(c)) begin
            first_char_next = c;
            phase_next      = PH_VALUE;
          end
        end
        PH_VALUE: if (is_eol(c)) phase_next = PH_DONE;
        default: ;
      endcase

      if (value_take) begin
        if (emit) chars_emitted_next = chars_emitted + 8'd1;
        if (mode == NM_START && (c == CH_PLUS || c == CH_MINUS)) begin
          if (c == CH_MINUS) negate_next = 1'b1;
          mode_next = NM_SIGNED;
        end else begin
          case (mode)
            NM_START, NM_SIGNED: begin
              if (c == CH_ZERO) mode_next = NM_ZERO;
              else if (d < 5'd10) begin
                acc_next  = 32'(d);
                mode_next = NM_DEC;
              end else mode_next = NM_STOP;
            end
            NM_ZERO: begin
              if (c == 8'h78 || c == 8'h58) mode_next = NM_XPFX;
              else if (d < 5'd8) begin
                acc_next  = 32'(d);
                mode_next = NM_OCT;
              end else mode_next = NM_STOP;
            end
            NM_XPFX: begin
              if (d < 5'd16) begin
                acc_next  = 32'(d);
                mode_next = NM_HEX;
              end else mode_next = NM_STOP;
            end
            NM_OCT, NM_DEC, NM_HEX: begin
              if ((mode == NM_OCT && d >= 5'd8) || (mode == NM_DEC && d >= 5'd10) ||
                  (mode == NM_HEX && d >= 5'd16)) begin
                mode_next = NM_STOP;
              end else if (!saturated) begin
                case (mode)
                  NM_OCT:  t = (acc_wide << 3) + 36'(d);
                  NM_DEC:  t = (acc_wide << 3) + (acc_wide << 1) + 36'(d);
                  default: t = (acc_wide << 4) + 36'(d);
                endcase
                if (t[35:32] != 4'd0) saturated_next = 1'b1;
                else acc_next = t[31:0];
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // result word
  always_comb begin
    word_load   = in_fire && ((c == CH_NUL) || emit);
    word_byte   = c;
    word_last   = 1'b0;
    word_found  = 1'b0;
    word_number = '0;
    word_class  = CLASS_TRUE;
    if (c == CH_NUL) begin
      word_last  = 1'b1;
      word_found = hit;
      word_class = CLASS_OTHER;
      if (hit) begin
        if (saturated) word_number = 32'hFFFF_FFFF;
        else if (negate) word_number = 32'd0 - acc;
        else word_number = acc;
        word_class = class_of(first_char);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SKIP;
      match_position <= '0;
      acc            <= '0;
      mode           <= NM_START;
      negate         <= 1'b0;
      saturated      <= 1'b0;
      first_char     <= '0;
      chars_emitted  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        phase          <= phase_next;
        match_position <= match_position_next;
        acc            <= acc_next;
        mode           <= mode_next;
        negate         <= negate_next;
        saturated      <= saturated_next;
        first_char     <= first_char_next;
        chars_emitted  <= chars_emitted_next;
      end
      if (word_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_load) begin
      value_byte <= word_byte;
      is_last    <= word_last;
      found      <= word_found;
      number     <= word_number;
      flag_class <= word_class;
    end
  end

  `HKVE_ASSERT_IMPLY(a_last_byte_zero, clk, rst, out_valid && is_last, value_byte == CH_NUL, "summary word carries a value byte")
  `HKVE_ASSERT_IMPLY(a_value_word_clean, clk, rst, out_valid && !is_last, !found && number == 32'd0 && flag_class == CLASS_TRUE, "value word carries summary fields")
  `HKVE_ASSERT_IMPLY(a_miss_summary, clk, rst, out_valid && is_last && !found, number == 32'd0 && flag_class == CLASS_OTHER, "miss summary not clean")
  `HKVE_ASSERT_NEXT(a_end_restart, clk, rst, in_fire && data_byte == CH_NUL, phase == PH_SKIP && match_position == '0 && out_valid && is_last, "header end did not restart")
  `HKVE_ASSERT_IMPLY(a_pos_bound, clk, rst, 1'b1, match_position <= POS_W'(KEY_BYTES), "match position beyond key")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the header key/value extractor: directed headers, then random ones
module testbench;
  import hkve_pkg::*;

  typedef struct {
    logic [7:0]  value_byte;
    logic        is_last;
    logic        found;
    logic [31:0] number;
    logic [1:0]  flag_class;
  } word_t;

  typedef struct {
    string       key;
    logic [3:0]  klen;
    logic [7:0]  limit;
    string       text;
    bit          typed;
    logic        found;
    logic [31:0] number;
    logic [1:0]  cls;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] write_index = '0;
  logic [CFG_DATA_W-1:0]  write_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             value_byte;
  logic                   is_last;
  logic                   found;
  logic [31:0]            number;
  logic [1:0]             flag_class;

  header_key_value_extract_top uut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_byte(value_byte), .is_last(is_last), .found(found),
    .number(number), .flag_class(flag_class)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // register copies and parser state
  logic [63:0] cfg_key;
  logic [3:0]  cfg_klen;
  logic [7:0]  cfg_limit;
  phase_t      ph;
  logic [3:0]  mpos;
  logic [31:0] acc;
  num_mode_t   nmode;
  logic        neg;
  logic        sat;
  logic [7:0]  first_ch;
  logic [7:0]  emitted;

  word_t       extract_words[$];
  logic [7:0]  header_bytes[$];
  bit          summary_fixed = 1'b0;
  word_t       fixed_summary;
  int          idle_mode = 0;
  logic        hold_go = 1'b0;
  logic        holding = 1'b0;
  int          mismatches = 0;
  int          words_seen = 0;
  int          summaries_found = 0;
  int          headers_sent = 0;
  int          bytes_sent = 0;
  int          settings_used = 0;

  string bool_words[8] = '{"true", "False", "yes", "No", "1", "0", "T", "n"};
  string odd_values[8] = '{"0x", "-", "", "0xz", "08", "0", "0x100000000", "+-1"};
  string hex_digits = "0123456789abcdefABCDEF";

  row_t dir_rows[25] = '{
    '{"a",        4'd1,  8'd255, "hdr\na=5",              1'b1, 1'b1, 32'd5, CLASS_OTHER},
    '{"Size",     4'd4,  8'd255, "x\015\nSize: 0x1F\015\n", 1'b1, 1'b1, 32'd31, CLASS_FALSE},
    '{"k",        4'd1,  8'd255, "k=7\nj=1",              1'b1, 1'b0, 32'd0, CLASS_OTHER},
    '{"n",        4'd1,  8'd255, "\nn:\n",                1'b1, 1'b1, 32'd0, CLASS_TRUE},
    '{"v",        4'd1,  8'd255, "\nv= -3",               1'b1, 1'b1, 32'hFFFFFFFD, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv=99999999999",       1'b1, 1'b1, 32'hFFFFFFFF, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv=-99999999999",      1'b1, 1'b1, 32'hFFFFFFFF, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv=017",               1'b1, 1'b1, 32'd15, CLASS_FALSE},
    '{"v",        4'd1,  8'd255, "\nv=0x",                1'b1, 1'b1, 32'd0, CLASS_FALSE},
    '{"v",        4'd1,  8'd255, "\nv=+",                 1'b1, 1'b1, 32'd0, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv=0xFFFFFFFF",        1'b1, 1'b1, 32'hFFFFFFFF, CLASS_FALSE},
    '{"v",        4'd1,  8'd255, "\nv=-0x1",              1'b1, 1'b1, 32'hFFFFFFFF, CLASS_OTHER},
    '{"",         4'd0,  8'd255, "\n  :yes",              1'b1, 1'b1, 32'd0, CLASS_TRUE},
    '{"ABCDEFGH", 4'd15, 8'd255, "\nABCDEFGH=Y",          1'b1, 1'b1, 32'd0, CLASS_TRUE},
    '{"v",        4'd1,  8'd0,   "\nv=123",               1'b1, 1'b1, 32'd123, CLASS_TRUE},
    '{"v",        4'd1,  8'd2,   "\nv=123",               1'b0, 1'b0, 32'd0, CLASS_OTHER},
    '{"ab",       4'd2,  8'd255, "\na\nab=1",             1'b1, 1'b1, 32'd1, CLASS_TRUE},
    '{"ab",       4'd2,  8'd255, "\naX ab=1\nab=t",       1'b1, 1'b1, 32'd0, CLASS_TRUE},
    '{"ab",       4'd3,  8'd255, "\nab=1",                1'b1, 1'b0, 32'd0, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv=1\nv=2",            1'b0, 1'b0, 32'd0, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "\nv \015\n\t= N",       1'b1, 1'b1, 32'd0, CLASS_FALSE},
    '{"v",        4'd1,  8'd255, "\nvx=1",                1'b1, 1'b0, 32'd0, CLASS_OTHER},
    '{"\377",     4'd1,  8'd255, "\n\377:\200",           1'b1, 1'b1, 32'd0, CLASS_OTHER},
    '{"v",        4'd1,  8'd255, "",                      1'b1, 1'b0, 32'd0, CLASS_OTHER},
    '{"key",      4'd3,  8'd255, "\n \t key\t:\t 42\015",  1'b0, 1'b0, 32'd0, CLASS_OTHER}
  };

  function automatic bit eol_ch(input logic [7:0] c);
    return c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit blank_ch(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [1:0] bool_class(input logic [7:0] c);
    case (c)
      CH_NUL, "T", "t", "1", "Y", "y": return CLASS_TRUE;
      "F", "f", "0", "N", "n":         return CLASS_FALSE;
      default:                         return CLASS_OTHER;
    endcase
  endfunction

  function automatic logic [63:0] pack_key(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  function automatic logic [3:0] key_span();
    return (cfg_klen > 4'd8) ? 4'd8 : cfg_klen;
  endfunction

  function automatic void clear_state();
    ph = PH_SKIP;
    mpos = '0;
    acc = '0;
    nmode = NM_START;
    neg = 1'b0;
    sat = 1'b0;
    first_ch = '0;
    emitted = '0;
  endfunction

  function automatic void sep_step(input logic [7:0] c);
    if (blank_ch(c) || eol_ch(c)) ph = PH_SEP;
    else if (c == CH_EQUAL || c == CH_COLON) ph = PH_BLANK;
    else ph = PH_SKIP;
  endfunction

  function automatic void key_step(input logic [7:0] c);
    if (c == cfg_key[{mpos[2:0], 3'b000} +: 8]) begin
      mpos = mpos + 4'd1;
      ph = (mpos >= key_span()) ? PH_SEP : PH_KEY;
    end else begin
      ph = eol_ch(c) ? PH_SPACE : PH_SKIP;
    end
  endfunction

  // strtoul base 0, saturating at 32 bits
  function automatic void num_step(input logic [7:0] c);
    logic [4:0]  d;
    logic [63:0] t;
    int unsigned radix;
    d = hex_val(c);
    radix = 0;
    if (nmode == NM_START && (c == CH_PLUS || c == CH_MINUS)) begin
      if (c == CH_MINUS) neg = 1'b1;
      nmode = NM_SIGNED;
      return;
    end
    case (nmode)
      NM_START, NM_SIGNED: begin
        if (c == CH_ZERO) nmode = NM_ZERO;
        else if (d < 10) begin
          acc = 32'(d);
          nmode = NM_DEC;
        end else nmode = NM_STOP;
      end
      NM_ZERO: begin
        if (c == "x" || c == "X") nmode = NM_XPFX;
        else if (d < 8) begin
          acc = 32'(d);
          nmode = NM_OCT;
        end else nmode = NM_STOP;
      end
      NM_XPFX: begin
        if (d < 16) begin
          acc = 32'(d);
          nmode = NM_HEX;
        end else nmode = NM_STOP;
      end
      NM_OCT:  radix = 8;
      NM_DEC:  radix = 10;
      NM_HEX:  radix = 16;
      default: radix = 0;
    endcase
    if (radix != 0) begin
      if (d >= radix) nmode = NM_STOP;
      else if (!sat) begin
        t = 64'(acc) * 64'(radix) + 64'(d);
        if (t > 64'h0000_0000_FFFF_FFFF) sat = 1'b1;
        else acc = t[31:0];
      end
    end
  endfunction

  // advances the parser by one byte; returns 1 with the word it emits
  function automatic bit extract_step(input logic [7:0] c, output word_t w);
    bit hit;
    w.value_byte = '0;
    w.is_last = 1'b0;
    w.found = 1'b0;
    w.number = '0;
    w.flag_class = CLASS_TRUE;
    if (c == CH_NUL) begin
      hit = (ph == PH_VALUE || ph == PH_DONE);
      w.is_last = 1'b1;
      w.found = hit;
      w.flag_class = CLASS_OTHER;
      if (hit) begin
        w.number = sat ? 32'hFFFF_FFFF : (neg ? 32'd0 - acc : acc);
        w.flag_class = bool_class(first_ch);
      end
      clear_state();
      return 1'b1;
    end
    case (ph)
      PH_SKIP: begin
        if (eol_ch(c)) ph = PH_SPACE;
        return 1'b0;
      end
      PH_SPACE: begin
        if (blank_ch(c) || eol_ch(c)) return 1'b0;
        mpos = '0;
        if (key_span() == 0) sep_step(c);
        else key_step(c);
        return 1'b0;
      end
      PH_KEY: begin
        key_step(c);
        return 1'b0;
      end
      PH_SEP: begin
        sep_step(c);
        return 1'b0;
      end
      PH_BLANK: begin
        if (blank_ch(c)) return 1'b0;
        if (eol_ch(c)) begin
          ph = PH_DONE;
          return 1'b0;
        end
        first_ch = c;
        ph = PH_VALUE;
      end
      PH_VALUE: begin
        if (eol_ch(c)) begin
          ph = PH_DONE;
          return 1'b0;
        end
      end
      default: return 1'b0;
    endcase
    num_step(c);
    if (emitted < cfg_limit) begin
      emitted = emitted + 8'd1;
      w.value_byte = c;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // header generation
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) header_bytes.push_back(s[i]);
  endfunction

  function automatic void add_eol();
    case ($urandom_range(0, 3))
      0: add_text("\n");
      1: add_text("\015\n");
      2: add_text("\015");
      default: add_text("\n\n");
    endcase
  endfunction

  function automatic void add_spacing(input int most, input bit line_ends);
    repeat ($urandom_range(0, most)) begin
      case ($urandom_range(0, line_ends ? 3 : 1))
        0: header_bytes.push_back(CH_SPACE);
        1: header_bytes.push_back(CH_TAB);
        2: header_bytes.push_back(CH_CR);
        default: header_bytes.push_back(CH_LF);
      endcase
    end
  endfunction

  function automatic void add_noise(input int most);
    repeat ($urandom_range(1, most)) header_bytes.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic void add_value();
    string s;
    s = "";
    case ($urandom_range(0, 8))
      0: s = $sformatf("%0d", $urandom);
      1: begin
        s = $urandom_range(0, 1) ? "0x" : "0X";
        repeat ($urandom_range(1, 9))
          s = $sformatf("%s%c", s, hex_digits[$urandom_range(0, 21)]);
      end
      2: s = $sformatf("0%0o", $urandom_range(0, 65535));
      3: s = $sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 99999));
      4: s = bool_words[$urandom_range(0, 7)];
      5: s = $sformatf("%0d%0d", $urandom_range(1, 9999999), $urandom);
      6: repeat ($urandom_range(0, 8)) header_bytes.push_back(8'($urandom_range(33, 126)));
      7: add_noise(6);
      default: s = odd_values[$urandom_range(0, 7)];
    endcase
    add_text(s);
  endfunction

  function automatic void build_header();
    int lines;
    int span;
    int cut;
    lines = $urandom_range(0, 4);
    span = key_span();
    repeat ($urandom_range(0, 6)) header_bytes.push_back(8'($urandom_range(1, 255)));
    add_eol();
    for (int l = 0; l < lines; l++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          add_spacing(2, 1'b0);
          for (int i = 0; i < span; i++) header_bytes.push_back(cfg_key[8*i +: 8]);
          add_spacing(2, 1'b1);
          header_bytes.push_back($urandom_range(0, 1) ? CH_EQUAL : CH_COLON);
          add_spacing(2, 1'b0);
          add_value();
        end
        6, 7: begin
          cut = (span == 0) ? 0 : $urandom_range(0, span - 1);
          for (int i = 0; i < cut; i++) header_bytes.push_back(cfg_key[8*i +: 8]);
          if ($urandom_range(0, 1)) add_noise(4);
          else begin
            for (int i = cut; i < span; i++) header_bytes.push_back(cfg_key[8*i +: 8]);
            add_spacing(1, 1'b0);
            header_bytes.push_back(8'($urandom_range(33, 126)));
          end
          add_text("=1");
        end
        default: add_noise(10);
      endcase
      if (l < lines - 1 || $urandom_range(0, 1)) add_eol();
    end
    header_bytes.push_back(CH_NUL);
  endfunction

  // bus driving
  task automatic load_config(input logic [63:0] k, input logic [3:0] kl, input logic [7:0] lim);
    write_enable <= 1'b1;
    write_index <= REG_KEY_TEXT;
    write_data <= k;
    @(posedge clk);
    write_index <= REG_KEY_LENGTH;
    write_data <= {$urandom, 28'($urandom), kl};
    @(posedge clk);
    write_index <= REG_VALUE_LIMIT;
    write_data <= {$urandom, 24'($urandom), lim};
    @(posedge clk);
    write_enable <= 1'b0;
    cfg_key = k;
    cfg_klen = kl;
    cfg_limit = lim;
    settings_used++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    int p;
    word_t w;
    p = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 18 : 0;
    if ($urandom_range(0, 99) < p) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < p);
    end
    in_valid <= 1'b1;
    data_byte <= c;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (c == CH_NUL) headers_sent++;
    if (extract_step(c, w)) begin
      if (w.is_last && summary_fixed) begin
        w.found = fixed_summary.found;
        w.number = fixed_summary.number;
        w.flag_class = fixed_summary.flag_class;
        summary_fixed = 1'b0;
      end
      extract_words.push_back(w);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (extract_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: checks every accepted word and sets out_ready
  initial begin : receiver
    word_t want;
    int p;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        words_seen++;
        if (extract_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: value %h last %b found %b number %h class %0d",
                     value_byte, is_last, found, number, flag_class);
        end else begin
          want = extract_words.pop_front();
          if (value_byte !== want.value_byte || is_last !== want.is_last ||
              found !== want.found || number !== want.number ||
              flag_class !== want.flag_class) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected %h/%b/%b/%h/%0d, got %h/%b/%b/%h/%0d", words_seen,
                       want.value_byte, want.is_last, want.found, want.number,
                       want.flag_class, value_byte, is_last, found, number, flag_class);
          end
          if (want.is_last && want.found) summaries_found++;
        end
      end
      p = (idle_mode == 2) ? 71 : (idle_mode == 3) ? 18 : 0;
      if (holding) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= p);
    end
  end

  // long output hold-off so the block fills and back-pressures its input
  initial begin : hold_off
    while (!hold_go) @(posedge clk);
    holding <= 1'b1;
    repeat (400) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin : stimulus
    logic [63:0] rkey;
    logic [3:0]  rlen;
    logic [7:0]  rlim;
    int          start;
    int          waited;
    cfg_key = '0;
    cfg_klen = 4'd1;
    cfg_limit = 8'd255;
    clear_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      settle();
      idle_mode = r % 4;
      load_config(pack_key(dir_rows[r].key), dir_rows[r].klen, dir_rows[r].limit);
      for (int i = 0; i < dir_rows[r].text.len(); i++) send_byte(dir_rows[r].text[i]);
      summary_fixed = dir_rows[r].typed;
      fixed_summary.found = dir_rows[r].found;
      fixed_summary.number = dir_rows[r].number;
      fixed_summary.flag_class = dir_rows[r].cls;
      send_byte(CH_NUL);
    end

    start = bytes_sent;
    for (int phase = 0; bytes_sent - start < 1450; phase++) begin
      settle();
      idle_mode = phase % 4;
      rkey = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
        if ($urandom_range(0, 4) != 0) rkey[8*i +: 8] = 8'($urandom_range(97, 122));
      case (phase)
        0: rlen = 4'd1;
        1: rlen = 4'd8;
        2: rlen = 4'd0;
        3: rlen = 4'd15;
        default: rlen = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
      endcase
      case (phase)
        0, 3: rlim = 8'd255;
        1: rlim = 8'd0;
        2: rlim = 8'd1;
        default: rlim = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(4, 255));
      endcase
      load_config(rkey, rlen, rlim);
      if (phase == 0) hold_go <= 1'b1;
      waited = bytes_sent;
      while (bytes_sent - waited < 160) begin
        header_bytes.delete();
        build_header();
        foreach (header_bytes[i]) send_byte(header_bytes[i]);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (extract_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (extract_words.size() != 0) begin
      mismatches += extract_words.size();
      $display("%0d words never arrived", extract_words.size());
    end
    $display("%0d bytes in %0d headers under %0d register settings, %0d words checked",
             bytes_sent, headers_sent, settings_used, words_seen);
    $display("%0d headers hit their key; all idle modes and one long output hold-off ran",
             summaries_found);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[header_key_value_extract_top.f]
+incdir+design
design/hkve_pkg.sv
design/header_key_value_extract_top.sv
dv/testbench.sv
